// ===== hw/rtl/lfr_pkg.sv =====
// ----------------------------------------------------------------------------
// LIN frame receiver package
// Shared types, codes and the CRC-8 byte update for the LIN frame receiver.
// ----------------------------------------------------------------------------
package lfr_pkg;

  typedef enum logic [1:0] {
    EV_HEADER = 2'd0,
    EV_GOOD   = 2'd1,
    EV_BAD    = 2'd2,
    EV_DROP   = 2'd3
  } event_t;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  localparam logic [7:0]  CRC_POLY        = 8'h8C;
  localparam logic [15:0] TIMEOUT_RESET   = 16'd100;
  localparam logic [15:0] IDLE_MAX        = 16'hFFFF;
  localparam logic [3:0]  HEADER_BYTES    = 4'd4;
  localparam logic [1:0]  LEAD_ZERO_BOTH  = 2'b11;

  typedef struct packed {
    event_t      event_res;
    logic [7:0]  frame_ident;
    logic [63:0] payload;
  } res_t;

  // Reflected CRC-8 update over one byte, no final xor.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/lfr_in_if.sv =====
// ----------------------------------------------------------------------------
// LIN frame receiver input channel
// Valid/ready channel that carries one received byte or one idle tick.
// ----------------------------------------------------------------------------
interface lfr_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink (input valid, input op, input rx_byte, output ready);
endinterface

// ===== hw/rtl/lfr_out_if.sv =====
// ----------------------------------------------------------------------------
// LIN frame receiver result channel
// Valid/ready channel that carries one frame event with identifier and data.
// ----------------------------------------------------------------------------
interface lfr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_res;
  logic [7:0]  frame_ident;
  logic [63:0] payload;

  modport source (output valid, output event_res, output frame_ident, output payload,
                  input ready);
  modport sink (input valid, input event_res, input frame_ident, input payload,
                output ready);
endinterface

// ===== hw/rtl/lin_frame_receiver_crc8.sv =====
// A result is registered into the output buffer. One byte or tick is taken per cycle
// while the second buffer entry is empty; the CRC update is an unrolled 8-step network.
// A two-entry output buffer keeps input flowing while one result waits to be taken.
// Reset (synchronous, rst_n low) clears the frame state, the idle count and the
// output buffer, and loads the idle timeout with 100.
// ----------------------------------------------------------------------------
// LIN frame receiver with CRC-8 check
// Splits a byte stream into header and response frames, checks the response
// CRC and drops partial frames after an idle timeout.
// ----------------------------------------------------------------------------
module lin_frame_receiver_crc8 #(
  parameter int PAYLOAD_BYTES = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  lfr_in_if.sink            in_ch,
  lfr_out_if.source         out_ch,
  input  logic              cfg_wr_en,
  input  logic [15:0]       cfg_wr_data
);

  localparam int DW = PAYLOAD_BYTES * 8;

  logic [15:0]   timeout_r;
  logic [3:0]    byte_cnt_r, byte_cnt_nxt;
  logic [1:0]    lead_zero_r, lead_zero_nxt;
  logic [7:0]    crc_r, crc_nxt;
  logic [DW-1:0] data_r, data_nxt;
  logic [15:0]   idle_r, idle_nxt;

  lfr_pkg::res_t main_r, main_nxt, skid_r, skid_nxt, res;
  logic          main_v_r, main_v_nxt, skid_v_r, skid_v_nxt, res_v;

  logic        accept;
  logic        out_pop;
  logic [3:0]  cnt_inc;
  logic [1:0]  lead_upd;
  logic [15:0] idle_inc;

  assign in_ch.ready = !skid_v_r;
  assign accept      = in_ch.valid && !skid_v_r;
  assign out_pop     = main_v_r && out_ch.ready;

  assign out_ch.valid       = main_v_r;
  assign out_ch.event_res   = main_r.event_res;
  assign out_ch.frame_ident = main_r.frame_ident;
  assign out_ch.payload     = main_r.payload;

  assign cnt_inc  = byte_cnt_r + 4'd1;
  assign idle_inc = (idle_r == lfr_pkg::IDLE_MAX) ? idle_r : idle_r + 16'd1;
  assign lead_upd = lead_zero_r |
                    {(byte_cnt_r == 4'd1) && (in_ch.rx_byte == 8'd0),
                     (byte_cnt_r == 4'd0) && (in_ch.rx_byte == 8'd0)};

  always_comb begin
    byte_cnt_nxt  = byte_cnt_r;
    lead_zero_nxt = lead_zero_r;
    crc_nxt       = crc_r;
    data_nxt      = data_r;
    idle_nxt      = idle_r;
    res_v         = 1'b0;
    res           = '{event_res: lfr_pkg::EV_HEADER, frame_ident: 8'd0, payload: 64'd0};
    if (accept) begin
      if (in_ch.op == lfr_pkg::OP_TICK) begin
        idle_nxt = idle_inc;
        if ((byte_cnt_r != 4'd0) && (idle_inc > timeout_r)) begin
          byte_cnt_nxt  = 4'd0;
          lead_zero_nxt = 2'd0;
          crc_nxt       = 8'd0;
          data_nxt      = '0;
          res_v         = 1'b1;
          res.event_res = lfr_pkg::EV_DROP;
        end
      end else begin
        idle_nxt      = 16'd0;
        byte_cnt_nxt  = cnt_inc;
        lead_zero_nxt = lead_upd;
        priority if ((cnt_inc == lfr_pkg::HEADER_BYTES) &&
                     (lead_upd == lfr_pkg::LEAD_ZERO_BOTH)) begin
          byte_cnt_nxt    = 4'd0;
          lead_zero_nxt   = 2'd0;
          crc_nxt         = 8'd0;
          data_nxt        = '0;
          res_v           = 1'b1;
          res.event_res   = lfr_pkg::EV_HEADER;
          res.frame_ident = in_ch.rx_byte;
        end else if ((lead_upd != lfr_pkg::LEAD_ZERO_BOTH) &&
                     (cnt_inc == 4'(PAYLOAD_BYTES + 1))) begin
          byte_cnt_nxt  = 4'd0;
          lead_zero_nxt = 2'd0;
          crc_nxt       = 8'd0;
          data_nxt      = '0;
          res_v         = 1'b1;
          res.event_res = (in_ch.rx_byte == crc_r) ? lfr_pkg::EV_GOOD : lfr_pkg::EV_BAD;
          res.payload   = 64'(data_r);
        end else begin
          if (byte_cnt_r < 4'(PAYLOAD_BYTES)) begin
            crc_nxt = lfr_pkg::crc8_byte(crc_r, in_ch.rx_byte);
            for (int i = 0; i < PAYLOAD_BYTES; i++) begin
              if (byte_cnt_r == 4'(i)) begin
                data_nxt[i*8 +: 8] = in_ch.rx_byte;
              end
            end
          end
        end
      end
    end
  end

  always_comb begin
    main_nxt   = main_r;
    main_v_nxt = main_v_r;
    skid_nxt   = skid_r;
    skid_v_nxt = skid_v_r;
    if (!main_v_r || out_pop) begin
      if (skid_v_r) begin
        main_nxt   = skid_r;
        main_v_nxt = 1'b1;
        skid_v_nxt = 1'b0;
      end else begin
        main_nxt   = res;
        main_v_nxt = res_v;
      end
    end else if (res_v) begin
      skid_nxt   = res;
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= lfr_pkg::TIMEOUT_RESET;
      byte_cnt_r  <= 4'd0;
      lead_zero_r <= 2'd0;
      crc_r       <= 8'd0;
      data_r      <= '0;
      idle_r      <= 16'd0;
      main_v_r    <= 1'b0;
      skid_v_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
      byte_cnt_r  <= byte_cnt_nxt;
      lead_zero_r <= lead_zero_nxt;
      crc_r       <= crc_nxt;
      data_r      <= data_nxt;
      idle_r      <= idle_nxt;
      main_v_r    <= main_v_nxt;
      skid_v_r    <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule
